/* rtl/rdsm_pkg.sv */
// Shared types, constants and helpers for the dot-star pattern matcher.
`timescale 1ns / 1ps
package rdsm_pkg;

  // Pattern special bytes.
  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  // Register file geometry: three 64-bit registers at byte addresses 8*i.
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PAT_W     = 8 * PAT_BYTES;

  // Register indexes, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_LEN  = 2'd0,
    REG_LOW  = 2'd1,
    REG_HIGH = 2'd2
  } reg_idx_t;

  // Per-transaction control broadcast to every cell of the row.
  typedef struct packed {
    logic       load;       // an input transaction is accepted this cycle
    logic       is_byte;    // 1: consume text_byte, 0: begin new text
    logic [7:0] text_byte;
  } step_t;

  // A pattern byte hits a text byte when it is a dot or the same byte.
  function automatic logic byte_hits(input logic [7:0] c, input logic [7:0] pc);
    byte_hits = (pc == DOT_CHAR) || (pc == c);
  endfunction

endpackage

/* rtl/rdsm_regs.sv */
// APB-style configuration registers holding the pattern length and bytes.
`timescale 1ns / 1ps
module rdsm_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdsm_pkg::ADDR_W-1:0] paddr,
  input  logic [rdsm_pkg::DATA_W-1:0] pwdata,
  output logic [rdsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [rdsm_pkg::LEN_W-1:0]  pattern_len,
  output logic [rdsm_pkg::PAT_W-1:0]  pattern
);
  import rdsm_pkg::*;

  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] low_r;
  logic [DATA_W-1:0] high_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:3]);

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_LEN:  len_r  <= pwdata[LEN_W-1:0];
        REG_LOW:  low_r  <= pwdata;
        REG_HIGH: high_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (idx)
      REG_LEN:  prdata = {{(DATA_W-LEN_W){1'b0}}, len_r};
      REG_LOW:  prdata = low_r;
      REG_HIGH: prdata = high_r;
      default:  prdata = '0;
    endcase
  end

  assign pattern_len = len_r;
  assign pattern     = {high_r, low_r};

endmodule

/* rtl/rdsm_cell.sv */
// One match cell: holds the row bit for a pattern prefix and computes its update.
`timescale 1ns / 1ps
module rdsm_cell #(
  parameter int unsigned POS = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rdsm_pkg::step_t step,
  input  logic [7:0]      pat_cur,     // pattern byte POS-1
  input  logic [7:0]      pat_prev,    // pattern byte POS-2
  input  logic            row_left,    // current row bit POS-1
  input  logic            next_left2,  // updated row bit POS-2
  output logic            row_q,
  output logic            row_next
);
  import rdsm_pkg::*;

  localparam bit HAS_PREV = (POS >= 2);

  logic row_r;
  logic row_nxt;
  logic is_star;
  logic rep_hit;

  // A star either skips its element (take bit POS-2 of the new row) or repeats
  // the preceding element once more on the current byte. A star with nothing
  // before it never matches.
  always_comb begin
    is_star = (pat_cur == STAR_CHAR);
    rep_hit = byte_hits(step.text_byte, pat_prev) && row_r;
    if (is_star && !HAS_PREV) begin
      row_nxt = 1'b0;
    end else if (is_star) begin
      row_nxt = step.is_byte ? (next_left2 || rep_hit) : next_left2;
    end else begin
      row_nxt = step.is_byte && row_left && byte_hits(step.text_byte, pat_cur);
    end
  end

  // The row bit advances once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 1'b0;
    end else if (step.load) begin
      row_r <= row_nxt;
    end
  end

  assign row_q    = row_r;
  assign row_next = row_nxt;

endmodule

/* rtl/regex_dot_star_matcher_top.sv */
// Top level of the dot-star pattern matcher: cell row, length select and output skid.
// Each accepted result is registered in the output register, or in the skid entry while a stalled result waits there.
// Throughput: one transaction per cycle while the skid entry is empty; the row of cells computes
// its next value through a carry chain that links every second cell.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (synchronous, rst_n low): row bit zero set, all others clear, registers zero.
`timescale 1ns / 1ps
module regex_dot_star_matcher_top #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [7:0]                  in_text_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_matched,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rdsm_pkg::ADDR_W-1:0] paddr,
  input  logic [rdsm_pkg::DATA_W-1:0] pwdata,
  output logic [rdsm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rdsm_pkg::*;

  localparam int unsigned IDX_W = $clog2(PATTERN_MAX + 1);

  logic [LEN_W-1:0]     cfg_len;
  logic [PAT_W-1:0]     cfg_pattern;
  logic [LEN_W-1:0]     len_sat;
  logic [PATTERN_MAX:0] row_cur;
  logic [PATTERN_MAX:0] row_new;
  step_t                step;
  logic                 accept;
  logic                 matched_new;

  logic row0_r;
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic skid_matched_r, skid_matched_nxt;

  rdsm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pattern_len (cfg_len),
    .pattern     (cfg_pattern)
  );

  // Input handshake and the step broadcast to the cells.
  assign in_ready       = !skid_valid_r;
  assign accept         = in_valid && in_ready;
  assign step.load      = accept;
  assign step.is_byte   = in_op;
  assign step.text_byte = in_text_byte;

  // Row bit zero: set for empty text, clear once any byte is consumed.
  assign row_cur[0] = row0_r;
  assign row_new[0] = !in_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= 1'b1;
    end else if (accept) begin
      row0_r <= row_new[0];
    end
  end

  // Row of cells, one per pattern prefix length.
  for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
    logic [7:0] pat_prev;
    logic       next_left2;

    if (j >= 2) begin : g_prev
      assign pat_prev   = cfg_pattern[8*(j-2) +: 8];
      assign next_left2 = row_new[j-2];
    end else begin : g_first
      assign pat_prev   = '0;
      assign next_left2 = 1'b0;
    end

    rdsm_cell #(
      .POS (j)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .pat_cur    (cfg_pattern[8*(j-1) +: 8]),
      .pat_prev   (pat_prev),
      .row_left   (row_cur[j-1]),
      .next_left2 (next_left2),
      .row_q      (row_cur[j]),
      .row_next   (row_new[j])
    );
  end

  // Pick the bit at the configured length, saturated to the row size.
  assign len_sat     = (cfg_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg_len;
  assign matched_new = row_new[len_sat[IDX_W-1:0]];

  // Output register with a one-entry skid behind it.
  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_matched_nxt  = out_matched_r;
    skid_valid_nxt   = skid_valid_r;
    skid_matched_nxt = skid_matched_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt   = skid_valid_r || accept;
      out_matched_nxt = skid_valid_r ? skid_matched_r : matched_new;
      skid_valid_nxt  = 1'b0;
    end else if (accept) begin
      skid_valid_nxt   = 1'b1;
      skid_matched_nxt = matched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r  <= out_matched_nxt;
    skid_matched_r <= skid_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

/* rtl/rdsm_checker.sv */
// Port-level checker for the dot-star pattern matcher and its bind statement.
`timescale 1ns / 1ps
module rdsm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched,
  input logic pready
);

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped low");

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Once a result is taken, the buffer has room for a new transaction.
  a_room_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready)
    else $error("input stalled after a result was taken");

  // A stalled result stays offered with the same value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_matched)))
    else $error("stalled result changed or vanished");

endmodule

bind regex_dot_star_matcher_top rdsm_checker u_rdsm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_matched (out_matched),
  .pready      (pready)
);

/* dv/tb_regex_dot_star_matcher_top.sv */
// Self-checking testbench for the dot-star pattern matcher: random and directed text against live patterns.
`timescale 1ns / 1ps
module tb_regex_dot_star_matcher_top;
  import rdsm_pkg::*;

  localparam int unsigned PAT_MAX        = 16;
  localparam logic        OP_BEGIN       = 1'b0;
  localparam logic        OP_BYTE        = 1'b1;
  localparam int unsigned ITEMS_PER_MODE = 600;
  localparam int unsigned SQUEEZE_CYCLES = 64;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned LATENCY_PAD    = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } text_item_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_op        = OP_BEGIN;
  logic [7:0]          in_text_byte = 8'h00;
  logic                out_ready    = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_matched;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Own copy of the matcher state and its registers.
  logic [PAT_MAX:0]    prefix_hits  = 17'd1;
  logic [4:0]          cfg_len      = '0;
  logic [PAT_W-1:0]    cfg_pattern  = '0;

  text_item_t          pending_text[$];
  logic                pending_verdicts[$];
  int unsigned         items_queued = 0;
  int unsigned         fail_count   = 0;
  int unsigned         tx_idle_pct  = 16;
  int unsigned         rx_stall_pct = 77;
  bit                  squeeze_go   = 1'b0;
  logic                rx_hold      = 1'b0;

  regex_dot_star_matcher_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_text_byte(in_text_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_matched (out_matched),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A pattern byte accepts a text byte when it is a dot or the same byte.
  function automatic logic pattern_byte_accepts(logic [7:0] pc, logic [7:0] c);
    return (pc == DOT_CHAR) || (pc == c);
  endfunction

  // Advances the prefix match row by one transaction and returns the full-pattern verdict.
  function automatic logic step_prefix_hits(logic op, logic [7:0] c);
    logic [PAT_MAX:0] nxt;
    logic [7:0]       pc;
    int unsigned      eff;
    nxt = '0;
    if (op == OP_BEGIN) begin
      // Empty text: only star pairs can extend the empty prefix.
      nxt[0] = 1'b1;
      for (int j = 2; j <= PAT_MAX; j++) begin
        if (cfg_pattern[8*(j-1) +: 8] == STAR_CHAR) nxt[j] = nxt[j-2];
      end
    end else begin
      for (int j = 1; j <= PAT_MAX; j++) begin
        pc = cfg_pattern[8*(j-1) +: 8];
        if (pc == STAR_CHAR) begin
          // A leading star has no element to repeat and never matches.
          if (j >= 2) begin
            nxt[j] = nxt[j-2] ||
                     (pattern_byte_accepts(cfg_pattern[8*(j-2) +: 8], c) && prefix_hits[j]);
          end
        end else begin
          nxt[j] = prefix_hits[j-1] && pattern_byte_accepts(pc, c);
        end
      end
    end
    prefix_hits = nxt;
    eff = (cfg_len > PAT_MAX) ? PAT_MAX : cfg_len;
    return prefix_hits[eff];
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic logic [PAT_W-1:0] pack_pattern(string s);
    logic [PAT_W-1:0] p;
    p = '0;
    for (int i = 0; i < s.len() && i < PAT_MAX; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  // Input side: launches queued text transactions, predicts each one as it is accepted.
  always @(posedge clk) begin : text_driver
    text_item_t nxt;
    if (in_valid && in_ready) begin
      pending_verdicts.push_back(step_prefix_hits(in_op, in_text_byte));
    end
    if (!in_valid || in_ready) begin
      if (pending_text.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = pending_text.pop_front();
        in_valid     <= 1'b1;
        in_op        <= nxt.op;
        in_text_byte <= nxt.text_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: compares each accepted verdict with the oldest prediction.
  always @(posedge clk) begin : verdict_monitor
    logic want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        log_failure($sformatf("result with nothing outstanding: matched=%0b", out_matched));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_matched !== want) begin
          log_failure($sformatf("matched: expected %0b, got %0b", want, out_matched));
        end
      end
    end
    out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Long receiver hold-off so the output buffer fills and input backs up.
  initial begin : rx_hold_off
    wait (squeeze_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LEN:  cfg_len = value[4:0];
      REG_LOW:  cfg_pattern[63:0] = value;
      REG_HIGH: cfg_pattern[127:64] = value;
      default: ;
    endcase
  endtask

  task automatic load_pattern(logic [PAT_W-1:0] bytes, logic [DATA_W-1:0] len);
    cfg_write(REG_LOW, bytes[63:0]);
    cfg_write(REG_HIGH, bytes[127:64]);
    cfg_write(REG_LEN, len);
  endtask

  task automatic push_item(logic op, logic [7:0] b);
    text_item_t it;
    it.op        = op;
    it.text_byte = b;
    pending_text.push_back(it);
    items_queued++;
  endtask

  // Text byte for a pattern element, now and then corrupted.
  task automatic push_text_for(logic [7:0] elem);
    if (elem == DOT_CHAR || $urandom_range(0, 19) == 0) begin
      push_item(OP_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      push_item(OP_BYTE, elem);
    end
  endtask

  // Waits until no transaction is queued, in flight or outstanding (or DRAIN_LIMIT is hit), then pads by LATENCY_PAD.
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    do begin
      @(negedge clk);
      n++;
    end while ((pending_text.size() != 0 || in_valid || pending_verdicts.size() != 0) &&
               n < DRAIN_LIMIT);
    repeat (LATENCY_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  // Random pattern, biased toward a small alphabet so matches are common.
  task automatic load_random_pattern();
    logic [PAT_W-1:0] p;
    logic [DATA_W-1:0] len;
    int unsigned r;
    for (int i = 0; i < PAT_MAX; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3)      p[8*i +: 8] = "a";
      else if (r < 5) p[8*i +: 8] = "b";
      else if (r < 7) p[8*i +: 8] = DOT_CHAR;
      else if (r < 9) p[8*i +: 8] = STAR_CHAR;
      else            p[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 9) == 0) p = {$urandom, $urandom, $urandom, $urandom};
    r = $urandom_range(0, 19);
    if (r == 0)      len = '0;
    else if (r == 1) len = DATA_W'($urandom_range(17, 31));
    else             len = DATA_W'($urandom_range(1, 16));
    load_pattern(p, len);
  endtask

  // One text: mostly built to follow the pattern, sometimes pure noise.
  task automatic add_text_sequence();
    int unsigned eff, k, reps;
    logic [7:0]  elem;
    bit          starred;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 12)) begin
        push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      return;
    end
    push_item(OP_BEGIN, 8'($urandom_range(0, 255)));
    eff = (cfg_len > PAT_MAX) ? PAT_MAX : cfg_len;
    k = 0;
    while (k < eff) begin
      elem    = cfg_pattern[8*k +: 8];
      starred = (k + 1 < eff) && (cfg_pattern[8*(k+1) +: 8] == STAR_CHAR);
      if (elem == STAR_CHAR) begin
        k++;
      end else begin
        reps = starred ? $urandom_range(0, 3) : 1;
        repeat (reps) push_text_for(elem);
        k += starred ? 2 : 1;
      end
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_text_for(DOT_CHAR);
  endtask

  initial begin : stimulus
    int unsigned target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Bytes before any begin run against the reset row and an empty pattern.
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BEGIN, 8'h00);
    wait_idle();

    // A leading star never matches.
    load_pattern(pack_pattern("*a"), 64'd2);
    push_item(OP_BEGIN, 8'hFF);
    push_item(OP_BYTE, "a");
    push_item(OP_BYTE, STAR_CHAR);
    wait_idle();

    // A star after a star repeats a literal star.
    load_pattern(pack_pattern("a**"), 64'd3);
    push_item(OP_BEGIN, 8'h00);
    push_item(OP_BYTE, "a");
    push_item(OP_BYTE, STAR_CHAR);
    push_item(OP_BYTE, STAR_CHAR);
    push_item(OP_BYTE, "b");
    wait_idle();

    // All-ones pattern with an oversized length that saturates to the full pattern.
    load_pattern({PAT_W{1'b1}}, 64'd31);
    push_item(OP_BEGIN, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'hFF);
    wait_idle();

    // Full-length dot-star pattern, then a pattern change in the middle of the text.
    load_pattern(pack_pattern(".*.*.*.*.*.*.*.*"), 64'd16);
    push_item(OP_BEGIN, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h55);
    wait_idle();
    load_pattern(pack_pattern("ab"), 64'd2);
    push_item(OP_BYTE, "a");
    push_item(OP_BYTE, "b");
    wait_idle();

    // Zero length matches only the empty text.
    load_pattern(pack_pattern("a"), 64'd0);
    push_item(OP_BEGIN, 8'h00);
    push_item(OP_BYTE, "a");
    wait_idle();

    // Random traffic under three idling schemes.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 16; rx_stall_pct = 77; end
        1: begin tx_idle_pct = 77; rx_stall_pct = 16; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      target = items_queued + ITEMS_PER_MODE;
      while (items_queued < target) begin
        load_random_pattern();
        repeat ($urandom_range(4, 10)) add_text_sequence();
        if (mode == 2 && !squeeze_go) begin
          repeat (12) add_text_sequence();
          squeeze_go = 1'b1;
        end
        wait_idle();
      end
    end

    wait_idle();
    if (pending_verdicts.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
